[src/tile_map_box_collision_resolve_macros.svh]
// Assertion macros used by the collision resolver checker.
// Depends on nothing; included by the checker file by its bare name.
`ifndef TILE_MAP_BOX_COLLISION_RESOLVE_MACROS_SVH
`define TILE_MAP_BOX_COLLISION_RESOLVE_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define TMBCR_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define TMBCR_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds across reset.
`define TMBCR_ASSERT_NXT_NR(lbl, clk_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/tmbcr_pkg.sv]
// Shared widths, parameter defaults and item codes of the tile map collision resolver.
// Depends on nothing; used by the top level and by its checker.
`timescale 1ns / 1ps

package tmbcr_pkg;

  // Port field widths.
  localparam int POS_W    = 16;
  localparam int ROW_W    = 6;
  localparam int HIT_W    = 3;
  localparam int MAX_HITS = 4;
  localparam int POS_MAX  = (1 << POS_W) - 1;

  // Corner coordinates reach 65535 plus the largest agent size.
  localparam int XW = 17;
  // Tile index of a corner, largest at the smallest tile size.
  localparam int QW = 10;
  // Signed width of the push arithmetic.
  localparam int CW = 20;

  // Writes reach only the first 64 rows and columns.
  localparam int MAX_STORE = 1 << ROW_W;

  // Parameter defaults.
  localparam int TILE_PX_DEF  = 64;
  localparam int AGENT_PX_DEF = 60;
  localparam int MAP_COLS_DEF = 64;
  localparam int MAP_ROWS_DEF = 64;

  typedef enum logic {
    KIND_WRITE   = 1'b0,
    KIND_RESOLVE = 1'b1
  } kind_t;

endpackage

[src/tile_map_box_collision_resolve.sv]
// Top level of the tile map collision resolver: map storage and the resolve pipeline.
// Depends on tmbcr_pkg.
`timescale 1ns / 1ps

// Tile map box collision resolver. The block keeps a map of solid and walkable
// tiles and pushes a square agent out of any solid tile that its corners land on.
// An input transfer with kind write sets one tile; it gives no result. An input
// transfer with kind resolve brings the agent's top-left corner in unsigned Q12.4
// and gives exactly one result from the last stage: the corrected position, clamped
// to the map, and the number of corners (0 to 4) that landed on solid tiles or
// outside the map. The block takes one transfer in every cycle except during map
// clearing or when all stages are full behind a stalled output; stages that hold
// no item close up when the output is stalled, so a finished result waiting at
// the output does not stop new transfers. The eleven stages are: capture and
// corner sums, the reciprocal multiply that turns each corner into a tile index,
// the back multiply, the index correction, the map read, the solid test, one push
// step per corner and the final clamp. The map is held four times over, one copy
// per corner, so that all four corners read in the same cycle; a write updates all
// copies as it passes the read stage, so a resolve that follows a write in the
// next cycle already sees the new tile. After reset the block clears the map one
// row per cycle, stalling its input until all stored rows (64 by default) are clear.
module tile_map_box_collision_resolve #(
  parameter int TILE_PX  = tmbcr_pkg::TILE_PX_DEF,
  parameter int AGENT_PX = tmbcr_pkg::AGENT_PX_DEF,
  parameter int MAP_COLS = tmbcr_pkg::MAP_COLS_DEF,
  parameter int MAP_ROWS = tmbcr_pkg::MAP_ROWS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_kind,
  input  logic [tmbcr_pkg::POS_W-1:0]   in_pos_x,
  input  logic [tmbcr_pkg::POS_W-1:0]   in_pos_y,
  input  logic [tmbcr_pkg::ROW_W-1:0]   in_tile_row,
  input  logic [tmbcr_pkg::ROW_W-1:0]   in_tile_col,
  input  logic                          in_tile_solid,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [tmbcr_pkg::POS_W-1:0]   out_new_x,
  output logic [tmbcr_pkg::POS_W-1:0]   out_new_y,
  output logic [tmbcr_pkg::HIT_W-1:0]   out_hit_count
);

  localparam int XW    = tmbcr_pkg::XW;
  localparam int QW    = tmbcr_pkg::QW;
  localparam int CW    = tmbcr_pkg::CW;
  localparam int HIT_W = tmbcr_pkg::HIT_W;
  localparam int ROW_W = tmbcr_pkg::ROW_W;
  localparam int NSTG  = 11;

  // Sizes in sixteenths of a pixel.
  localparam int TILE_Q_I  = TILE_PX * 16;
  localparam int AGENT_Q_I = AGENT_PX * 16;

  // Corner coordinate divided by the tile size: multiply by a reciprocal scaled
  // by 2^XW. Since every corner is below 2^XW, the estimate is at most one low.
  localparam int RECIP_I = (1 << XW) / TILE_Q_I;
  localparam int PW      = XW + QW + 1;
  localparam logic [PW-1:0] RECIP_P = PW'(RECIP_I);

  localparam logic [XW-1:0] TQ_X  = XW'(TILE_Q_I);
  localparam logic [XW-1:0] HT_X  = XW'(TILE_Q_I / 2);
  localparam logic [XW-1:0] AQ_X  = XW'(AGENT_Q_I);

  localparam logic signed [CW-1:0] HALF_A = CW'(AGENT_Q_I / 2);
  localparam logic signed [CW-1:0] MIN_D  = CW'(AGENT_Q_I / 2 + TILE_Q_I / 2);

  // Clamp limits: map extent minus one, no more than the port range.
  localparam int EXT_X_I = MAP_COLS * TILE_Q_I - 1;
  localparam int EXT_Y_I = MAP_ROWS * TILE_Q_I - 1;
  localparam int HI_X_I  = (EXT_X_I > tmbcr_pkg::POS_MAX) ? tmbcr_pkg::POS_MAX : EXT_X_I;
  localparam int HI_Y_I  = (EXT_Y_I > tmbcr_pkg::POS_MAX) ? tmbcr_pkg::POS_MAX : EXT_Y_I;
  localparam logic signed [CW-1:0] HI_X = CW'(HI_X_I);
  localparam logic signed [CW-1:0] HI_Y = CW'(HI_Y_I);

  // Stored part of the map; tiles beyond it are walkable for good.
  localparam int NC = (MAP_COLS < tmbcr_pkg::MAX_STORE) ? MAP_COLS : tmbcr_pkg::MAX_STORE;
  localparam int NR = (MAP_ROWS < tmbcr_pkg::MAX_STORE) ? MAP_ROWS : tmbcr_pkg::MAX_STORE;
  localparam int CI = $clog2(NC);
  localparam int RW = $clog2(NR);

  localparam logic [QW-1:0] MAP_COLS_Q = QW'(MAP_COLS);
  localparam logic [QW-1:0] MAP_ROWS_Q = QW'(MAP_ROWS);
  localparam logic [QW-1:0] NC_Q       = QW'(NC);
  localparam logic [QW-1:0] NR_Q       = QW'(NR);
  localparam logic [ROW_W:0] NC_W      = (ROW_W + 1)'(NC);
  localparam logic [ROW_W:0] NR_W      = (ROW_W + 1)'(NR);
  localparam logic [RW-1:0] LAST_ROW   = RW'(NR - 1);

  // Item fields that travel through the front stages. Index 0 of cx and cy is
  // the top-left corner, index 1 the far edge.
  typedef struct packed {
    tmbcr_pkg::kind_t     kind;
    logic [ROW_W-1:0]     trow;
    logic [ROW_W-1:0]     tcol;
    logic                 tsol;
    logic [1:0][XW-1:0]   cx;
    logic [1:0][XW-1:0]   cy;
  } front_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
  } pos_t;

  // Corner i uses column i[0] and row i[1].
  typedef struct packed {
    logic [3:0]           solid;
    logic [HIT_W-1:0]     hits;
    logic [1:0][XW-1:0]   tcx;
    logic [1:0][XW-1:0]   tcy;
  } pctx_t;

  // One push-out step against the tile under corner ci, if that tile is solid.
  function automatic pos_t push_step(pos_t p, pctx_t c, logic [1:0] ci);
    logic signed [CW-1:0] tx;
    logic signed [CW-1:0] ty;
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    logic signed [CW-1:0] adx;
    logic signed [CW-1:0] ady;
    logic signed [CW-1:0] xd;
    logic signed [CW-1:0] yd;
    pos_t r;
    tx  = $signed(CW'(c.tcx[ci[0]]));
    ty  = $signed(CW'(c.tcy[ci[1]]));
    dx  = p.x + HALF_A - tx;
    dy  = p.y + HALF_A - ty;
    adx = (dx < 0) ? -dx : dx;
    ady = (dy < 0) ? -dy : dy;
    xd  = MIN_D - adx;
    yd  = MIN_D - ady;
    r   = p;
    if (c.solid[ci] && (xd > 0) && (yd > 0)) begin
      if (xd < yd) begin
        r.x = (dx < 0) ? (p.x - xd) : (p.x + xd);
      end else begin
        r.y = (dy < 0) ? (p.y - yd) : (p.y + yd);
      end
    end
    return r;
  endfunction

  // Stage handshake: a stage loads when it is empty or its content moves on.
  logic [NSTG:1] v_r;
  logic [NSTG:1] vin;
  logic [NSTG:1] rdy;

  // Map clearing after reset.
  logic          clr_busy_r;
  logic [RW-1:0] clr_row_r;

  // Front stages.
  front_t             s1_r, s2_r, s3_r, s4_r;
  logic [1:0][QW-1:0] s2_qx_r, s2_qy_r;
  logic [1:0][QW-1:0] s3_qx_r, s3_qy_r;
  logic [1:0][XW-1:0] s3_prx_r, s3_pry_r;
  logic [1:0][QW-1:0] s4_col_r, s4_row_r;
  logic [1:0][XW-1:0] s4_tcx_r, s4_tcy_r;

  logic [1:0][PW-1:0] mulx, muly;
  logic [1:0][XW-1:0] prx, pry;
  logic [1:0][XW-1:0] remx, remy;
  logic [1:0]         corx, cory;
  logic [1:0][QW-1:0] colq, rowq;
  logic [1:0][XW-1:0] tcx, tcy;

  // Map read stage.
  logic [NC-1:0]      rd5_r [4];
  logic [RW-1:0]      rd_row [4];
  logic [3:0][CI-1:0] s5_csel_r;
  logic [3:0]         s5_oob_r;
  logic [3:0]         s5_inm_r;
  logic [1:0][XW-1:0] s5_tcx_r, s5_tcy_r;
  logic [tmbcr_pkg::POS_W-1:0] s5_x0_r, s5_y0_r;

  logic          wr_en;
  logic [RW-1:0] wr_row;
  logic [CI-1:0] wr_col;

  // Push stages: index 6 holds the start position, 7 to 10 one step each.
  pos_t  pp_r  [6:10];
  pctx_t ctx_r [6:10];
  logic [3:0] solid6;

  logic [tmbcr_pkg::POS_W-1:0] out_x_r, out_y_r;
  logic [HIT_W-1:0]            out_hits_r;
  logic signed [CW-1:0]        fin_x, fin_y;

  // ---------------------------------------------------------------------------
  // Handshake and valid bits.
  // ---------------------------------------------------------------------------
  always_comb begin
    rdy[NSTG] = !v_r[NSTG] || !out_stall;
    for (int k = NSTG - 1; k >= 1; k--) begin
      rdy[k] = !v_r[k] || rdy[k + 1];
    end
  end

  assign in_stall = !rdy[1] || clr_busy_r;

  always_comb begin
    vin[1] = in_valid && !in_stall;
    for (int k = 2; k <= NSTG; k++) begin
      vin[k] = v_r[k - 1];
    end
    // A write item ends at the map; it leaves no result.
    vin[5] = v_r[4] && (s4_r.kind == tmbcr_pkg::KIND_RESOLVE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 1; k <= NSTG; k++) begin
        if (rdy[k]) begin
          v_r[k] <= vin[k];
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Clearing pass: one stored row per cycle after reset.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_row_r  <= '0;
    end else if (clr_busy_r) begin
      if (clr_row_r == LAST_ROW) begin
        clr_busy_r <= 1'b0;
      end
      clr_row_r <= clr_row_r + 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: capture the transfer and form the far-edge corners.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      s1_r.kind  <= tmbcr_pkg::kind_t'(in_kind);
      s1_r.trow  <= in_tile_row;
      s1_r.tcol  <= in_tile_col;
      s1_r.tsol  <= in_tile_solid;
      s1_r.cx[0] <= XW'(in_pos_x);
      s1_r.cx[1] <= XW'(in_pos_x) + AQ_X;
      s1_r.cy[0] <= XW'(in_pos_y);
      s1_r.cy[1] <= XW'(in_pos_y) + AQ_X;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: tile index estimate by reciprocal multiply.
  // ---------------------------------------------------------------------------
  always_comb begin
    for (int j = 0; j < 2; j++) begin
      mulx[j] = PW'(s1_r.cx[j]) * RECIP_P;
      muly[j] = PW'(s1_r.cy[j]) * RECIP_P;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      s2_r <= s1_r;
      for (int j = 0; j < 2; j++) begin
        s2_qx_r[j] <= mulx[j][XW +: QW];
        s2_qy_r[j] <= muly[j][XW +: QW];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: multiply the estimate back by the tile size.
  // ---------------------------------------------------------------------------
  always_comb begin
    for (int j = 0; j < 2; j++) begin
      prx[j] = XW'(s2_qx_r[j]) * TQ_X;
      pry[j] = XW'(s2_qy_r[j]) * TQ_X;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      s3_r     <= s2_r;
      s3_qx_r  <= s2_qx_r;
      s3_qy_r  <= s2_qy_r;
      s3_prx_r <= prx;
      s3_pry_r <= pry;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: correct the estimate by one where the remainder is a whole tile,
  // and form the tile centres.
  // ---------------------------------------------------------------------------
  always_comb begin
    for (int j = 0; j < 2; j++) begin
      remx[j] = s3_r.cx[j] - s3_prx_r[j];
      remy[j] = s3_r.cy[j] - s3_pry_r[j];
      corx[j] = (remx[j] >= TQ_X);
      cory[j] = (remy[j] >= TQ_X);
      colq[j] = s3_qx_r[j] + QW'(corx[j]);
      rowq[j] = s3_qy_r[j] + QW'(cory[j]);
      tcx[j]  = s3_prx_r[j] + (corx[j] ? TQ_X : '0) + HT_X;
      tcy[j]  = s3_pry_r[j] + (cory[j] ? TQ_X : '0) + HT_X;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      s4_r     <= s3_r;
      s4_col_r <= colq;
      s4_row_r <= rowq;
      s4_tcx_r <= tcx;
      s4_tcy_r <= tcy;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 5: map access. Writes and reads both happen as an item leaves stage 4,
  // so items meet the map in their arrival order.
  // ---------------------------------------------------------------------------
  assign wr_en  = v_r[4] && rdy[5] && (s4_r.kind == tmbcr_pkg::KIND_WRITE) &&
                  ({1'b0, s4_r.trow} < NR_W) && ({1'b0, s4_r.tcol} < NC_W);
  assign wr_row = s4_r.trow[RW-1:0];
  assign wr_col = s4_r.tcol[CI-1:0];

  for (genvar g = 0; g < 4; g++) begin : g_copy
    logic [NC-1:0] mem [NR];

    assign rd_row[g] = s4_row_r[g / 2][RW-1:0];

    always_ff @(posedge clk) begin
      if (clr_busy_r) begin
        mem[clr_row_r] <= '0;
      end else if (wr_en) begin
        mem[wr_row][wr_col] <= s4_r.tsol;
      end
      if (rdy[5]) begin
        rd5_r[g] <= mem[rd_row[g]];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      for (int i = 0; i < 4; i++) begin
        s5_csel_r[i] <= s4_col_r[i % 2][CI-1:0];
        s5_oob_r[i]  <= (s4_col_r[i % 2] >= MAP_COLS_Q) || (s4_row_r[i / 2] >= MAP_ROWS_Q);
        s5_inm_r[i]  <= (s4_col_r[i % 2] < NC_Q) && (s4_row_r[i / 2] < NR_Q);
      end
      s5_tcx_r <= s4_tcx_r;
      s5_tcy_r <= s4_tcy_r;
      s5_x0_r  <= s4_r.cx[0][tmbcr_pkg::POS_W-1:0];
      s5_y0_r  <= s4_r.cy[0][tmbcr_pkg::POS_W-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 6: solid test per corner and hit count. A corner outside the map is
  // solid; a corner inside the map but beyond the stored part is walkable.
  // ---------------------------------------------------------------------------
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      solid6[i] = s5_oob_r[i] | (s5_inm_r[i] & rd5_r[i][s5_csel_r[i]]);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[6]) begin
      pp_r[6].x        <= $signed(CW'(s5_x0_r));
      pp_r[6].y        <= $signed(CW'(s5_y0_r));
      ctx_r[6].solid   <= solid6;
      ctx_r[6].hits    <= HIT_W'(solid6[0]) + HIT_W'(solid6[1]) +
                          HIT_W'(solid6[2]) + HIT_W'(solid6[3]);
      ctx_r[6].tcx     <= s5_tcx_r;
      ctx_r[6].tcy     <= s5_tcy_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stages 7 to 10: one push step per corner, in corner order. Each step works
  // on the position left by the step before.
  // ---------------------------------------------------------------------------
  for (genvar s = 7; s <= 10; s++) begin : g_push
    always_ff @(posedge clk) begin
      if (rdy[s]) begin
        pp_r[s]  <= push_step(pp_r[s - 1], ctx_r[s - 1], 2'(s - 7));
        ctx_r[s] <= ctx_r[s - 1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 11: clamp to the map and hold the result for the output transfer.
  // ---------------------------------------------------------------------------
  always_comb begin
    fin_x = pp_r[10].x;
    fin_y = pp_r[10].y;
    if (fin_x < 0) begin
      fin_x = '0;
    end else if (fin_x > HI_X) begin
      fin_x = HI_X;
    end
    if (fin_y < 0) begin
      fin_y = '0;
    end else if (fin_y > HI_Y) begin
      fin_y = HI_Y;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[NSTG]) begin
      out_x_r    <= fin_x[tmbcr_pkg::POS_W-1:0];
      out_y_r    <= fin_y[tmbcr_pkg::POS_W-1:0];
      out_hits_r <= ctx_r[10].hits;
    end
  end

  assign out_valid     = v_r[NSTG];
  assign out_new_x     = out_x_r;
  assign out_new_y     = out_y_r;
  assign out_hit_count = out_hits_r;

endmodule

[src/tmbcr_checker.sv]
// Port-level checker of the tile map collision resolver, bound to the top level.
// Depends on tmbcr_pkg and tile_map_box_collision_resolve_macros.svh.
`timescale 1ns / 1ps
`include "tile_map_box_collision_resolve_macros.svh"

module tmbcr_checker #(
  parameter int TILE_PX  = tmbcr_pkg::TILE_PX_DEF,
  parameter int MAP_COLS = tmbcr_pkg::MAP_COLS_DEF,
  parameter int MAP_ROWS = tmbcr_pkg::MAP_ROWS_DEF
) (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [tmbcr_pkg::POS_W-1:0] out_new_x,
  input logic [tmbcr_pkg::POS_W-1:0] out_new_y,
  input logic [tmbcr_pkg::HIT_W-1:0] out_hit_count
);

  localparam int EXT_X_I = MAP_COLS * TILE_PX * 16 - 1;
  localparam int EXT_Y_I = MAP_ROWS * TILE_PX * 16 - 1;
  localparam int HI_X_I  = (EXT_X_I > tmbcr_pkg::POS_MAX) ? tmbcr_pkg::POS_MAX : EXT_X_I;
  localparam int HI_Y_I  = (EXT_Y_I > tmbcr_pkg::POS_MAX) ? tmbcr_pkg::POS_MAX : EXT_Y_I;
  localparam logic [tmbcr_pkg::POS_W-1:0] HI_X = tmbcr_pkg::POS_W'(HI_X_I);
  localparam logic [tmbcr_pkg::POS_W-1:0] HI_Y = tmbcr_pkg::POS_W'(HI_Y_I);
  localparam logic [tmbcr_pkg::HIT_W-1:0] HIT_LIM = tmbcr_pkg::HIT_W'(tmbcr_pkg::MAX_HITS);

  // A result that is held back stays put until its transfer.
  `TMBCR_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_new_x) && $stable(out_new_y) && $stable(out_hit_count), "result changed while stalled")

  // Only four corners can hit.
  `TMBCR_ASSERT_IMP(a_hit_range, clk, rst_n, out_valid, out_hit_count <= HIT_LIM, "hit count above four")

  // The clamp keeps every result inside the map.
  `TMBCR_ASSERT_IMP(a_pos_range, clk, rst_n, out_valid, (out_new_x <= HI_X) && (out_new_y <= HI_Y), "result outside the map")

  // The map clearing pass starts with reset, and the input waits for it.
  `TMBCR_ASSERT_NXT_NR(a_clear_stall, clk, !rst_n, in_stall && !out_valid, "input open during map clearing")

endmodule

bind tile_map_box_collision_resolve tmbcr_checker #(
  .TILE_PX  (TILE_PX),
  .MAP_COLS (MAP_COLS),
  .MAP_ROWS (MAP_ROWS)
) u_tmbcr_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_new_x     (out_new_x),
  .out_new_y     (out_new_y),
  .out_hit_count (out_hit_count)
);
